/* design/pmst_pkg.sv */
// Shared constants for the Prim spanning-tree block.
// Stream field layout, op codes and the result limit. No dependencies.
package pmst_pkg;

    localparam int VTX_W   = 4;    // vertex fields on the stream
    localparam int WIN_W   = 16;   // edge weight on the stream
    localparam int MAX_RES = 16;   // result words per run, status included
    localparam int CNT_W   = $clog2(MAX_RES);

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    typedef logic [VTX_W-1:0] t_vtx;

endpackage

/* design/pmst_ram.sv */
// Simple dual-port synchronous RAM, one write and one read port.
// Read data registered. No dependencies.
module pmst_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/prim_minimum_spanning_tree_top.sv */
// Prim minimum spanning tree over a graph held in an adjacency RAM.
// Edge load steps per word: accept, read, compare and write, mirrored write;
// the writes are skipped when an edge as light is already held, and an ignored edge is only accepted.
// Run: per tree vertex, a relaxation pass over all vertices, one adjacency read a cycle,
// then an emit step that waits while the output stalls.
// Reset (i_rst_n low, synchronous) clears control state, then a clearing pass
// empties the adjacency RAM before input is taken.
module prim_minimum_spanning_tree_top #(
    parameter int VERTICES    = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // vertex_a, vertex_b, edge_weight, start_vertex
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // tree_a, tree_b, tree_weight, spans_all
    output logic        m_axis_tuser,   // has_edge
    output logic        m_axis_tlast    // last
);

    localparam int VB    = $clog2(VERTICES);
    localparam int ADEP  = VERTICES * VERTICES;
    localparam int AW    = $clog2(ADEP);
    localparam int WB    = WEIGHT_BITS;
    localparam logic signed [32:0] W_HI = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ARD   = 3'd2;
    localparam logic [2:0] ST_AWAB  = 3'd3;
    localparam logic [2:0] ST_AWBA  = 3'd4;
    localparam logic [2:0] ST_RELAX = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;
    localparam logic [2:0] ST_STAT  = 3'd7;

    // input fields
    pmst_pkg::t_vtx                    in_a, in_b, in_s;
    logic signed [pmst_pkg::WIN_W-1:0] in_w;
    logic signed [32:0]                w_ext, w_sat;
    logic                              in_ok;

    assign in_a  = s_axis_tdata[3:0];
    assign in_b  = s_axis_tdata[7:4];
    assign in_w  = s_axis_tdata[23:8];
    assign in_s  = s_axis_tdata[27:24];
    assign w_ext = 33'(in_w);
    assign w_sat = (w_ext > W_HI) ? W_HI : ((w_ext < W_LO) ? W_LO : w_ext);
    assign in_ok = (int'(in_a) < VERTICES) && (int'(in_b) < VERTICES) && (in_a != in_b);

    logic [2:0]                  r_st, n_st;
    logic [AW:0]                 r_clr;
    logic [VB-1:0]               r_a, r_b, r_v;
    logic signed [WB-1:0]        r_w;
    logic [VERTICES-1:0]         r_present, r_tree, r_kvld;
    logic [VB:0]                 r_u;
    logic                        r_pv;
    logic [VB-1:0]               r_pu;
    logic                        r_hp;
    logic [VB-1:0]               r_pk, r_pp;
    logic signed [WB-1:0]        r_pw;
    logic [pmst_pkg::CNT_W-1:0]  r_n;
    logic                        r_ovld, r_ouser, r_olast;
    logic [31:0]                 r_odata;

    logic                        acc, out_free;
    logic                        emit_edge, emit_stat;
    assign s_axis_tready = (r_st == ST_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovld || m_axis_tready;
    assign emit_edge     = (r_st == ST_EMIT) && out_free && r_hp &&
                           (int'(r_n) != pmst_pkg::MAX_RES - 1);
    assign emit_stat     = (r_st == ST_STAT) && out_free;

    // adjacency RAM: {valid, weight}
    logic            adj_we, adj_re;
    logic [AW-1:0]   adj_waddr, adj_raddr;
    logic [WB:0]     adj_wdata, adj_rdata;
    logic            adj_vld;
    logic signed [WB-1:0] adj_w;
    assign adj_vld = adj_rdata[WB];
    assign adj_w   = adj_rdata[WB-1:0];

    // key RAM: {parent, weight}; validity held in r_kvld
    logic               key_we, key_re;
    logic [VB-1:0]      key_waddr, key_raddr;
    logic [VB+WB-1:0]   key_wdata, key_rdata;
    logic signed [WB-1:0] key_w;
    logic [VB-1:0]      key_p;
    assign key_w = key_rdata[WB-1:0];
    assign key_p = key_rdata[VB+WB-1:WB];

    pmst_ram #(.DEPTH(ADEP), .WIDTH(WB + 1)) u_adj (
        .i_clk  (i_clk),
        .i_we   (adj_we),
        .i_waddr(adj_waddr),
        .i_wdata(adj_wdata),
        .i_re   (adj_re),
        .i_raddr(adj_raddr),
        .o_rdata(adj_rdata)
    );

    pmst_ram #(.DEPTH(VERTICES), .WIDTH(VB + WB)) u_key (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(key_waddr),
        .i_wdata(key_wdata),
        .i_re   (key_re),
        .i_raddr(key_raddr),
        .o_rdata(key_rdata)
    );

    // relaxation of one neighbour, with the running pick
    logic                 upd, nvld, cand, take;
    logic signed [WB-1:0] nw;
    logic [VB-1:0]        np;
    logic                 issue, last_proc;

    assign upd  = adj_vld && !r_tree[r_pu] &&
                  (!r_kvld[r_pu] || adj_w < key_w || (adj_w == key_w && r_v < key_p));
    assign nvld = r_kvld[r_pu] || upd;
    assign nw   = upd ? adj_w : key_w;
    assign np   = upd ? r_v : key_p;
    assign cand = !r_tree[r_pu] && nvld;
    assign take = cand && (!r_hp || nw < r_pw);

    assign issue     = (r_st == ST_RELAX) && (int'(r_u) < VERTICES);
    assign last_proc = (r_st == ST_RELAX) && r_pv && (int'(r_pu) == VERTICES - 1);

    always_comb begin
        adj_we    = 1'b0;
        adj_waddr = AW'(r_a * VERTICES + r_b);
        adj_wdata = {1'b1, r_w};
        adj_re    = 1'b0;
        adj_raddr = AW'(r_a * VERTICES + r_b);
        case (r_st)
            ST_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr[AW-1:0];
                adj_wdata = '0;
            end
            ST_ARD: adj_re = 1'b1;
            ST_AWAB: adj_we = !adj_vld || r_w < adj_w;
            ST_AWBA: begin
                adj_we    = 1'b1;
                adj_waddr = AW'(r_b * VERTICES + r_a);
            end
            ST_RELAX: begin
                adj_re    = issue;
                adj_raddr = AW'(r_v * VERTICES + r_u[VB-1:0]);
            end
            default: ;
        endcase
    end

    assign key_re    = issue;
    assign key_raddr = r_u[VB-1:0];
    assign key_we    = (r_st == ST_RELAX) && r_pv;
    assign key_waddr = r_pu;
    assign key_wdata = {np, nw};

    logic [VB-1:0]     e_lo, e_hi;
    logic signed [32:0] pw_ext;
    assign e_lo   = (r_pp < r_pk) ? r_pp : r_pk;
    assign e_hi   = (r_pp < r_pk) ? r_pk : r_pp;
    assign pw_ext = 33'(r_pw);

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_CLEAR: if (int'(r_clr) == ADEP - 1) n_st = ST_IDLE;
            ST_IDLE: begin
                if (acc) begin
                    if (s_axis_tuser == pmst_pkg::OP_RUN) begin
                        n_st = (int'(in_s) < VERTICES) ? ST_RELAX : ST_STAT;
                    end else if (in_ok) begin
                        n_st = ST_ARD;
                    end
                end
            end
            ST_ARD:  n_st = ST_AWAB;
            ST_AWAB: n_st = adj_we ? ST_AWBA : ST_IDLE;
            ST_AWBA: n_st = ST_IDLE;
            ST_RELAX: if (last_proc) n_st = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    if (!r_hp || int'(r_n) == pmst_pkg::MAX_RES - 1) n_st = ST_STAT;
                    else n_st = ST_RELAX;
                end
            end
            ST_STAT: if (out_free) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_CLEAR;
            r_clr     <= '0;
            r_present <= '0;
            r_tree    <= '0;
            r_kvld    <= '0;
            r_u       <= '0;
            r_pv      <= 1'b0;
            r_hp      <= 1'b0;
            r_n       <= '0;
            r_ovld    <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (emit_edge || emit_stat) r_ovld <= 1'b1;
            else if (m_axis_tready) r_ovld <= 1'b0;

            if (acc) begin
                if (s_axis_tuser == pmst_pkg::OP_RUN) begin
                    r_kvld <= '0;
                    r_tree <= (int'(in_s) < VERTICES) ? (VERTICES'(1) << in_s) : '0;
                    r_n    <= '0;
                    r_u    <= '0;
                    r_pv   <= 1'b0;
                    r_hp   <= 1'b0;
                    r_v    <= VB'(in_s);
                end else if (in_ok) begin
                    r_present <= r_present | (VERTICES'(1) << in_a) |
                                 (VERTICES'(1) << in_b);
                end
            end

            if (r_st == ST_RELAX) begin
                if (issue) r_u <= r_u + 1'b1;
                r_pv <= issue;
                r_pu <= r_u[VB-1:0];
                if (r_pv) begin
                    if (upd) r_kvld[r_pu] <= 1'b1;
                    if (take) begin
                        r_hp <= 1'b1;
                        r_pk <= r_pu;
                        r_pw <= nw;
                        r_pp <= np;
                    end
                end
            end

            if (emit_edge) begin
                r_ouser <= 1'b1;
                r_olast <= 1'b0;
                r_odata <= {7'd0, 1'b0, pw_ext[15:0],
                            pmst_pkg::VTX_W'(e_hi), pmst_pkg::VTX_W'(e_lo)};
                r_tree[r_pk] <= 1'b1;
                r_v  <= r_pk;
                r_n  <= r_n + 1'b1;
                r_u  <= '0;
                r_pv <= 1'b0;
                r_hp <= 1'b0;
            end

            if (emit_stat) begin
                r_ouser <= 1'b0;
                r_olast <= 1'b1;
                r_odata <= {7'd0, ((r_present & ~r_tree) == '0), 24'd0};
            end
        end
    end

    // add-edge payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a <= VB'(in_a);
            r_b <= VB'(in_b);
            r_w <= WB'(w_sat);
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    a_clr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_CLEAR) |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    a_key_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (key_we && key_re) |-> (key_waddr != key_raddr))
        else $error("key RAM read and write collide");

    a_edge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[3:0] < m_axis_tdata[7:4]))
        else $error("tree edge endpoints out of order");

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser)
        else $error("last word carries an edge");

endmodule

/* test/prim_minimum_spanning_tree_checker.sv */
// Stream checker for the Prim spanning-tree block: predicts the tree words
// for each accepted run command and compares them with the output stream.
// Depends on pmst_pkg.
`timescale 1ns / 1ps

module prim_minimum_spanning_tree_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // vertex_a, vertex_b, edge_weight, start_vertex
    input  logic        i_s_tuser,   // op
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // tree_a, tree_b, tree_weight, spans_all
    input  logic        i_m_tuser,   // has_edge
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NV = 16;

    typedef struct packed {
        logic [3:0]  tree_a;
        logic [3:0]  tree_b;
        logic [15:0] tree_weight;
        logic        has_edge;
        logic        spans_all;
        logic        last;
    } t_tree_word;

    logic               adj_ok [NV][NV];
    logic signed [15:0] adj_w  [NV][NV];
    logic [NV-1:0]      present;
    t_tree_word         tree_q[$];

    assign o_pending = tree_q.size();

    function automatic void grow_tree(input logic [3:0] root);
        logic [NV-1:0]      joined;
        logic               key_ok [NV];
        logic signed [15:0] key_w  [NV];
        int                 parent [NV];
        int                 pick;
        int                 emitted;
        t_tree_word         wd;
        joined = '0;
        emitted = 0;
        for (int u = 0; u < NV; u++) begin
            key_ok[u] = 0;
            key_w[u] = 0;
            parent[u] = 0;
        end
        pick = root;
        joined[root] = 1'b1;
        forever begin
            // relax neighbours of the vertex that just joined
            for (int u = 0; u < NV; u++) begin
                if (adj_ok[pick][u] && !joined[u] &&
                    (!key_ok[u] || adj_w[pick][u] < key_w[u] ||
                     (adj_w[pick][u] == key_w[u] && pick < parent[u]))) begin
                    key_ok[u] = 1;
                    key_w[u] = adj_w[pick][u];
                    parent[u] = pick;
                end
            end
            if (emitted >= pmst_pkg::MAX_RES - 1) break;
            pick = NV;
            for (int u = 0; u < NV; u++)
                if (!joined[u] && key_ok[u] && (pick == NV || key_w[u] < key_w[pick]))
                    pick = u;
            if (pick == NV) break;
            joined[pick] = 1'b1;
            wd = '0;
            wd.tree_a = 4'((parent[pick] < pick) ? parent[pick] : pick);
            wd.tree_b = 4'((parent[pick] < pick) ? pick : parent[pick]);
            wd.tree_weight = key_w[pick];
            wd.has_edge = 1'b1;
            tree_q.push_back(wd);
            emitted++;
        end
        wd = '0;
        wd.spans_all = ((present & ~joined) == '0);
        wd.last = 1'b1;
        tree_q.push_back(wd);
    endfunction

    always @(posedge i_clk) begin
        logic [3:0]         va, vb;
        logic signed [15:0] w;
        t_tree_word         got, want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            present = '0;
            tree_q.delete();
            for (int i = 0; i < NV; i++)
                for (int j = 0; j < NV; j++) begin
                    adj_ok[i][j] = 0;
                    adj_w[i][j] = 0;
                end
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                va = i_s_tdata[3:0];
                vb = i_s_tdata[7:4];
                w  = i_s_tdata[23:8];
                if (i_s_tuser == pmst_pkg::OP_RUN) begin
                    grow_tree(i_s_tdata[27:24]);
                end else if (va != vb) begin
                    if (!adj_ok[va][vb] || w < adj_w[va][vb]) begin
                        adj_ok[va][vb] = 1; adj_w[va][vb] = w;
                        adj_ok[vb][va] = 1; adj_w[vb][va] = w;
                    end
                    present[va] = 1'b1;
                    present[vb] = 1'b1;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.tree_a      = i_m_tdata[3:0];
                got.tree_b      = i_m_tdata[7:4];
                got.tree_weight = i_m_tdata[23:8];
                got.spans_all   = i_m_tdata[24];
                got.has_edge    = i_m_tuser;
                got.last        = i_m_tlast;
                if (tree_q.size() == 0) begin
                    $error("unexpected output word %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = tree_q.pop_front();
                    if (got != want) begin
                        if (got.tree_a != want.tree_a)
                            $error("tree_a exp %0d got %0d", want.tree_a, got.tree_a);
                        if (got.tree_b != want.tree_b)
                            $error("tree_b exp %0d got %0d", want.tree_b, got.tree_b);
                        if (got.tree_weight != want.tree_weight)
                            $error("tree_weight exp %0d got %0d",
                                   $signed(want.tree_weight), $signed(got.tree_weight));
                        if (got.has_edge != want.has_edge)
                            $error("has_edge exp %0d got %0d", want.has_edge, got.has_edge);
                        if (got.spans_all != want.spans_all)
                            $error("spans_all exp %0d got %0d",
                                   want.spans_all, got.spans_all);
                        if (got.last != want.last)
                            $error("last exp %0d got %0d", want.last, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/prim_minimum_spanning_tree_top_tb.sv */
// Testbench top for the Prim spanning-tree block: clock, reset, command
// stimulus, output back-pressure and verdict. Uses the checker and pmst_pkg.
`timescale 1ns / 1ps

module prim_minimum_spanning_tree_top_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid, s_tready, s_tuser;
    logic [31:0] s_tdata;   // vertex_a, vertex_b, edge_weight, start_vertex
    logic        m_tvalid, m_tready, m_tuser, m_tlast;
    logic [31:0] m_tdata;   // tree_a, tree_b, tree_weight, spans_all
    int          fail_count, pending;
    int          idle_cycles;
    bit          hold_sink;

    prim_minimum_spanning_tree_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser), .m_axis_tlast(m_tlast)
    );

    prim_minimum_spanning_tree_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // valid stays high across back-to-back words; dropped only for a gap
    task automatic send_word(input logic op, input logic [3:0] va, input logic [3:0] vb,
                             input logic [15:0] w, input logic [3:0] root);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (g) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, root, w, vb, va};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
    endtask

    task automatic add_edge(input logic [3:0] va, input logic [3:0] vb,
                            input logic [15:0] w);
        send_word(pmst_pkg::OP_ADD, va, vb, w, 4'($urandom));
    endtask

    task automatic run_tree(input logic [3:0] root);
        send_word(pmst_pkg::OP_RUN, 4'($urandom), 4'($urandom), 16'($urandom), root);
    endtask

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 7));     // ties likely
            1: return 16'h8000 + 16'($urandom_range(0, 3));
            2: return 16'h7FFF - 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    // output back-pressure
    initial begin
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) m_tready <= 1'b0;
            else if ($urandom_range(0, 99) < 12) begin
                m_tready <= 1'b0;
                repeat (gap_len() + 1) @(negedge i_clk);
                m_tready <= 1'b1;
            end else m_tready <= 1'b1;
        end
    end

    // long receiver hold-off while commands keep coming
    initial begin
        hold_sink = 1'b0;
        #3000;
        @(negedge i_clk);
        hold_sink = 1'b1;
        repeat (3000) @(negedge i_clk);
        hold_sink = 1'b0;
    end

    // watchdog on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int nv;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty graph, then a small graph with ties and a loop
        run_tree(4'd0);
        run_tree(4'd15);
        add_edge(4'd3, 4'd3, 16'd5);        // self-loop ignored
        add_edge(4'd0, 4'd1, 16'h7FFF);
        add_edge(4'd1, 4'd0, 16'h8000);     // lighter parallel edge wins
        add_edge(4'd0, 4'd1, 16'd9);        // heavier parallel edge dropped
        add_edge(4'd1, 4'd2, 16'd4);
        add_edge(4'd0, 4'd2, 16'd4);        // equal weight links into 2
        add_edge(4'd2, 4'd3, 16'd4);
        add_edge(4'd14, 4'd15, 16'hFFFF);   // separate component
        run_tree(4'd0);
        run_tree(4'd15);
        run_tree(4'd9);                      // vertex without edges
        for (int i = 4; i < 14; i++) add_edge(i[3:0], 4'(i + 1), 16'(i));
        add_edge(4'd13, 4'd14, 16'h1234);
        run_tree(4'd0);                      // tree stays within vertices 0 to 3
        run_tree(4'd7);

        // random: well-formed graphs followed by runs, with some noise
        for (int k = 0; k < 75; k++) begin
            nv = $urandom_range(2, 16);
            repeat ($urandom_range(1, 10)) begin
                logic [3:0] a, b;
                a = 4'($urandom_range(0, nv - 1));
                b = ($urandom_range(0, 9) == 0) ? a : 4'($urandom_range(0, nv - 1));
                add_edge(a, b, rand_weight());
            end
            run_tree(4'($urandom_range(0, 15)));
            if (k == 40) begin
                // quiet pause until all tree words are out
                idle_input();
                while (pending != 0) @(negedge i_clk);
            end
        end

        idle_input();
        while (pending != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
design/pmst_pkg.sv
design/pmst_ram.sv
design/prim_minimum_spanning_tree_top.sv
test/prim_minimum_spanning_tree_checker.sv
test/prim_minimum_spanning_tree_top_tb.sv
